@@ sv/abbs_pkg.sv @@
// ----------------------------------------------------------------------------
// abbs_pkg
// Shared types and constants for the alert beep burst sequencer: the command
// and phase codes, the register indexes, the settings struct and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package abbs_pkg;

  // Number of distinct alert kinds tracked in the active mask.
  localparam int ALERT_KINDS = 32;
  localparam int KIND_W      = (ALERT_KINDS > 1) ? $clog2(ALERT_KINDS) : 1;

  // Largest accepted volume percent.
  localparam logic [7:0] VOLUME_MAX = 8'd100;

  // Saturation value of the millisecond counter.
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [15:0] TONE_HZ_RST  = 16'd880;
  localparam logic [15:0] TONE_MS_RST  = 16'd140;
  localparam logic [15:0] GAP_MS_RST   = 16'd120;
  localparam logic [15:0] REPEAT_MS_RST = 16'd5000;
  localparam logic [7:0]  TONES_RST    = 8'd3;

  // Request command codes.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ALERT  = 2'd1,
    CMD_ENABLE = 2'd2,
    CMD_VOLUME = 2'd3
  } cmd_t;

  // Sequencer phases.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TONE   = 2'd1,
    PH_GAP    = 2'd2,
    PH_REPEAT = 2'd3
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_HZ   = 3'd0,
    REG_TONE_MS   = 3'd1,
    REG_GAP_MS    = 3'd2,
    REG_REPEAT_MS = 3'd3,
    REG_TONES     = 3'd4
  } reg_idx_t;

  // Current settings as seen by the sequencer core.
  typedef struct packed {
    logic [15:0] tone_hz;
    logic [15:0] tone_ms;
    logic [15:0] gap_ms;
    logic [15:0] repeat_ms;
    logic [7:0]  tones_per_burst;
  } cfg_t;

endpackage

`default_nettype wire

@@ sv/abbs_if.sv @@
// ----------------------------------------------------------------------------
// abbs_in_if / abbs_out_if
// Valid/ready channels of the sequencer: event requests in, status results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface abbs_in_if import abbs_pkg::*; ();
  logic       valid;
  logic       ready;
  cmd_t       cmd;
  logic [7:0] alert_kind;
  logic       raised;
  logic       enable_value;
  logic [7:0] volume_value;

  modport source (output valid, cmd, alert_kind, raised, enable_value, volume_value,
                  input ready);
  modport sink   (input valid, cmd, alert_kind, raised, enable_value, volume_value,
                  output ready);
endinterface

interface abbs_out_if import abbs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [15:0] tone_freq;
  logic [6:0]  volume_out;
  logic        alerting;
  phase_t      phase_out;

  modport source (output valid, tone_on, tone_freq, volume_out, alerting, phase_out,
                  input ready);
  modport sink   (input valid, tone_on, tone_freq, volume_out, alerting, phase_out,
                  output ready);
endinterface

`default_nettype wire

@@ sv/abbs_cfg.sv @@
// ----------------------------------------------------------------------------
// abbs_cfg
// Configuration register file: tone frequency, tone length, gap, repeat wait
// and tones per burst, written through a simple indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module abbs_cfg import abbs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  // Register writes; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tone_hz         <= TONE_HZ_RST;
      cfg_r.tone_ms         <= TONE_MS_RST;
      cfg_r.gap_ms          <= GAP_MS_RST;
      cfg_r.repeat_ms       <= REPEAT_MS_RST;
      cfg_r.tones_per_burst <= TONES_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_TONE_HZ:   cfg_r.tone_hz         <= cfg_wdata;
        REG_TONE_MS:   cfg_r.tone_ms         <= cfg_wdata;
        REG_GAP_MS:    cfg_r.gap_ms          <= cfg_wdata;
        REG_REPEAT_MS: cfg_r.repeat_ms       <= cfg_wdata;
        REG_TONES:     cfg_r.tones_per_burst <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ sv/abbs_core.sv @@
// ----------------------------------------------------------------------------
// abbs_core
// Sequencer core: input register, alert/enable/volume state, the burst phase
// machine and the result register with its handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module abbs_core import abbs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  abbs_in_if.sink    in_chan,
  abbs_out_if.source out_chan
);

  localparam logic [7:0] KIND_LIMIT = 8'(ALERT_KINDS);

  // Input stage.
  logic       s1_vld_r;
  cmd_t       s1_cmd_r;
  logic [7:0] s1_kind_r;
  logic       s1_raised_r;
  logic       s1_en_r;
  logic [7:0] s1_vol_r;

  // Architectural state.
  logic [ALERT_KINDS-1:0] mask_r, mask_nxt;
  logic                   en_r, en_nxt;
  logic [6:0]             req_r, req_nxt;
  logic [6:0]             app_r, app_nxt;
  phase_t                 ph_r, ph_nxt;
  logic [7:0]             idx_r, idx_nxt;
  logic [15:0]            cnt_r, cnt_nxt;
  logic                   np_r, np_nxt;

  // Result stage.
  logic        out_vld_r;
  logic        tone_on_r, tone_on_nxt;
  logic [15:0] freq_r, freq_nxt;
  logic        alerting_r, alerting_nxt;

  logic advance;
  logic in_acc;
  logic step;

  // The pipeline moves whenever the result register is free or being taken.
  assign advance = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !s1_vld_r || advance;
  assign in_acc = in_chan.valid && in_chan.ready;
  assign step = s1_vld_r && advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= in_chan.cmd;
      s1_kind_r   <= in_chan.alert_kind;
      s1_raised_r <= in_chan.raised;
      s1_en_r     <= in_chan.enable_value;
      s1_vol_r    <= in_chan.volume_value;
    end
  end

  // Next state for one request.
  always_comb begin
    logic        notify;
    logic        do_top;
    logic        active;
    logic [15:0] cnt_inc;
    logic [15:0] tone_len;
    logic [7:0]  burst_len;
    logic [7:0]  idx_inc;
    logic        last_tone;

    mask_nxt = mask_r;
    en_nxt   = en_r;
    req_nxt  = req_r;
    app_nxt  = app_r;
    ph_nxt   = ph_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    np_nxt   = np_r;
    notify   = 1'b0;
    do_top   = 1'b0;

    cnt_inc   = (cnt_r < COUNT_MAX) ? cnt_r + 16'd1 : cnt_r;
    tone_len  = (cfg.tone_ms != 16'd0) ? cfg.tone_ms : 16'd1;
    burst_len = (cfg.tones_per_burst != 8'd0) ? cfg.tones_per_burst : 8'd1;
    idx_inc   = idx_r + 8'd1;
    last_tone = ({1'b0, idx_r} + 9'd1) >= {1'b0, burst_len};

    // Event decode and the millisecond tick.
    case (s1_cmd_r)
      CMD_TICK: begin
        case (ph_r)
          PH_TONE: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= tone_len) begin
              // End of a tone: go on in the burst, wait, restart or go idle.
              if (!(en_r && (mask_r != '0))) begin
                do_top = 1'b1;
              end else if (last_tone) begin
                if (np_r || cfg.repeat_ms == 16'd0) begin
                  do_top = 1'b1;
                end else begin
                  ph_nxt  = PH_REPEAT;
                  cnt_nxt = 16'd0;
                end
              end else if (np_r) begin
                do_top = 1'b1;
              end else if (cfg.gap_ms == 16'd0) begin
                ph_nxt  = PH_TONE;
                idx_nxt = idx_inc;
                cnt_nxt = 16'd0;
              end else begin
                ph_nxt  = PH_GAP;
                cnt_nxt = 16'd0;
              end
            end
          end
          PH_GAP: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= cfg.gap_ms) begin
              ph_nxt  = PH_TONE;
              idx_nxt = idx_inc;
              cnt_nxt = 16'd0;
            end
          end
          PH_REPEAT: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= cfg.repeat_ms) begin
              do_top = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_ALERT: begin
        if (s1_kind_r < KIND_LIMIT) begin
          mask_nxt[s1_kind_r[KIND_W-1:0]] = s1_raised_r;
          notify = 1'b1;
        end
      end
      CMD_ENABLE: begin
        en_nxt = s1_en_r;
        notify = 1'b1;
      end
      CMD_VOLUME: begin
        if (s1_vol_r <= VOLUME_MAX && s1_vol_r != {1'b0, req_r}) begin
          req_nxt = s1_vol_r[6:0];
          notify  = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // A notification during a tone waits for the tone to end.
    if (notify) begin
      np_nxt = 1'b1;
      if (ph_r != PH_TONE) begin
        do_top = 1'b1;
      end
    end

    active = en_nxt && (mask_nxt != '0);

    // Top of the sequence: apply volume, then start a burst or go idle.
    if (do_top) begin
      app_nxt = req_nxt;
      np_nxt  = 1'b0;
      ph_nxt  = active ? PH_TONE : PH_IDLE;
      idx_nxt = 8'd0;
      cnt_nxt = 16'd0;
    end

    tone_on_nxt  = (ph_nxt == PH_TONE) && en_nxt;
    freq_nxt     = tone_on_nxt ? cfg.tone_hz : 16'd0;
    alerting_nxt = active;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      en_r   <= 1'b0;
      req_r  <= 7'd0;
      app_r  <= 7'd0;
      ph_r   <= PH_IDLE;
      idx_r  <= 8'd0;
      cnt_r  <= 16'd0;
      np_r   <= 1'b0;
    end else if (step) begin
      mask_r <= mask_nxt;
      en_r   <= en_nxt;
      req_r  <= req_nxt;
      app_r  <= app_nxt;
      ph_r   <= ph_nxt;
      idx_r  <= idx_nxt;
      cnt_r  <= cnt_nxt;
      np_r   <= np_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tone_on_r  <= tone_on_nxt;
      freq_r     <= freq_nxt;
      alerting_r <= alerting_nxt;
    end
  end

  // Volume and phase in the result are the state just written.
  assign out_chan.valid      = out_vld_r;
  assign out_chan.tone_on    = tone_on_r;
  assign out_chan.tone_freq  = freq_r;
  assign out_chan.volume_out = app_r;
  assign out_chan.alerting   = alerting_r;
  assign out_chan.phase_out  = ph_r;

endmodule

`default_nettype wire

@@ sv/alert_beep_burst_sequencer.sv @@
// ----------------------------------------------------------------------------
// alert_beep_burst_sequencer
// Alert beeper controller: tracks active alert kinds, enable and volume, and
// steps tone bursts, gaps and repeat waits on millisecond tick requests.
// ----------------------------------------------------------------------------
// Each request (tick, alert raise/clear, enable change, volume change) gives
// exactly one status result. The block takes one request per clock cycle
// while results are taken as they are offered; a request is captured in the
// input register, updates the sequencer state as it moves on into the result
// register and is offered from there until taken. Requests stall only while
// a result waits to be taken and the input register is full. Settings are
// to be written through the cfg_ port while no request is in flight (the block
// itself does not enforce this) and take effect on the next one.
`default_nettype none

module alert_beep_burst_sequencer import abbs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  abbs_in_if.sink                    in_chan,
  abbs_out_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;

  // Settings registers.
  abbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer datapath and handshake.
  abbs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
